>>> rtl/core/c2mp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// c2mp_pkg: shared definitions for the complex to magnitude/phase converter
// Sample widths, pipeline depths, the arctangent table and the vector type
// that flows from the input stage into the rotation pipeline.
// ============================================================================
package c2mp_pkg;

  // Width of one signed input component and of each output field.
  localparam int SAMPLE_WIDTH  = 16;
  // Number of rotation iterations in the phase pipeline.
  localparam int CORDIC_STAGES = 18;

  // Fraction bits appended to the inputs before rotation.
  localparam int GUARD_BITS = 16;
  // Angle accumulator: 2^ANGLE_BITS units per full turn.
  localparam int ANGLE_BITS = 32;

  // The rotated vector grows by the CORDIC gain (about 1.65) and by sqrt(2),
  // so two extra bits above the scaled input keep it in range.
  localparam int XY_W = SAMPLE_WIDTH + GUARD_BITS + 2;
  localparam int XY_EXT = XY_W - SAMPLE_WIDTH - GUARD_BITS;

  // Squares and their sum.
  localparam int SQ_W = 2 * SAMPLE_WIDTH;
  // Square root remainder width.
  localparam int REM_W = SAMPLE_WIDTH + 2;

  // Latency of the magnitude path: sum, one stage per root bit, rounding.
  localparam int MAG_LAT  = SAMPLE_WIDTH + 2;
  // Common latency after the input stage.
  localparam int PIPE_LAT = (CORDIC_STAGES > MAG_LAT) ? CORDIC_STAGES : MAG_LAT;

  // Right shift that turns the accumulator into the output angle.
  localparam int PHASE_SHIFT = ANGLE_BITS - SAMPLE_WIDTH;
  localparam logic [ANGLE_BITS-1:0] PHASE_ROUND = ANGLE_BITS'((2 ** PHASE_SHIFT) / 2);

  // A quarter turn, used by the pre-rotation into the right half plane.
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(2 ** (ANGLE_BITS - 2));

  // atan(2^-i) in units of 2^32 per turn, rounded to nearest.
  localparam logic [ANGLE_BITS-1:0] ATAN_TABLE [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Vector and angle carried through the rotation pipeline.
  typedef struct packed {
    logic signed [XY_W-1:0]       x;
    logic signed [XY_W-1:0]       y;
    logic        [ANGLE_BITS-1:0] z;
  } cordic_vec_t;

endpackage

>>> rtl/core/c2mp_prep.sv
`timescale 1ns / 1ps
// ============================================================================
// c2mp_prep: input stage
// Scales the sample, folds the left half plane onto the right half plane
// with a quarter turn, and squares both components for the magnitude path.
// ============================================================================
module c2mp_prep
  import c2mp_pkg::*;
(
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [SAMPLE_WIDTH-1:0] real_part,
  input  logic signed [SAMPLE_WIDTH-1:0] imag_part,
  output cordic_vec_t                    vec,
  output logic        [SQ_W-1:0]         re_sq,
  output logic        [SQ_W-1:0]         im_sq
);

  logic signed [XY_W-1:0] x_scaled;
  logic signed [XY_W-1:0] y_scaled;
  logic signed [SQ_W-1:0] re_prod;
  logic signed [SQ_W-1:0] im_prod;
  cordic_vec_t            vec_next;

  assign x_scaled = {{XY_EXT{real_part[SAMPLE_WIDTH-1]}}, real_part, {GUARD_BITS{1'b0}}};
  assign y_scaled = {{XY_EXT{imag_part[SAMPLE_WIDTH-1]}}, imag_part, {GUARD_BITS{1'b0}}};

  assign re_prod = real_part * real_part;
  assign im_prod = imag_part * imag_part;

  always_comb begin
    vec_next.x = x_scaled;
    vec_next.y = y_scaled;
    vec_next.z = '0;
    if (real_part[SAMPLE_WIDTH-1]) begin
      if (!imag_part[SAMPLE_WIDTH-1]) begin
        vec_next.x = y_scaled;
        vec_next.y = -x_scaled;
        vec_next.z = QUARTER_TURN;
      end else begin
        vec_next.x = -y_scaled;
        vec_next.y = x_scaled;
        vec_next.z = -QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec   <= vec_next;
      re_sq <= unsigned'(re_prod);
      im_sq <= unsigned'(im_prod);
    end
  end

endmodule

>>> rtl/core/c2mp_cordic.sv
`timescale 1ns / 1ps
// ============================================================================
// c2mp_cordic: vectoring rotation pipeline
// One registered micro-rotation per stage drives y toward zero and
// accumulates the angle; the final accumulator leaves after the last stage.
// ============================================================================
module c2mp_cordic
  import c2mp_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  cordic_vec_t           vec_in,
  output logic [ANGLE_BITS-1:0] z_out
);

  cordic_vec_t stage [0:CORDIC_STAGES];

  assign stage[0] = vec_in;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    logic signed [XY_W-1:0] xc;
    logic signed [XY_W-1:0] yc;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    cordic_vec_t            vec_next;

    assign xc = stage[i].x;
    assign yc = stage[i].y;
    assign xs = xc >>> i;
    assign ys = yc >>> i;

    always_comb begin
      if (!yc[XY_W-1]) begin
        vec_next.x = xc + ys;
        vec_next.y = yc - xs;
        vec_next.z = stage[i].z + ATAN_TABLE[i];
      end else begin
        vec_next.x = xc - ys;
        vec_next.y = yc + xs;
        vec_next.z = stage[i].z - ATAN_TABLE[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage[i+1] <= vec_next;
      end
    end
  end

  assign z_out = stage[CORDIC_STAGES].z;

endmodule

>>> rtl/core/c2mp_sqrt.sv
`timescale 1ns / 1ps
// ============================================================================
// c2mp_sqrt: pipelined magnitude
// Adds the squares, extracts one root bit per stage by restoring square
// root, then rounds the root to the nearest integer.
// ============================================================================
module c2mp_sqrt
  import c2mp_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic [SQ_W-1:0]         re_sq,
  input  logic [SQ_W-1:0]         im_sq,
  output logic [SAMPLE_WIDTH-1:0] magnitude
);

  logic [SQ_W-1:0]         src  [0:SAMPLE_WIDTH];
  logic [REM_W-1:0]        rem  [0:SAMPLE_WIDTH];
  logic [SAMPLE_WIDTH-1:0] root [0:SAMPLE_WIDTH];

  always_ff @(posedge clk) begin
    if (en) begin
      src[0]  <= re_sq + im_sq;
      rem[0]  <= '0;
      root[0] <= '0;
    end
  end

  for (genvar k = 0; k < SAMPLE_WIDTH; k++) begin : g_bit
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign rem_sh = {rem[k][REM_W-3:0], src[k][SQ_W-1 -: 2]};
    assign trial  = {root[k], 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        src[k+1]  <= {src[k][SQ_W-3:0], 2'b00};
        rem[k+1]  <= fits ? (rem_sh - trial) : rem_sh;
        root[k+1] <= {root[k][SAMPLE_WIDTH-2:0], fits};
      end
    end
  end

  // The root rounds up when the remainder exceeds it, that is when the
  // sum lies above (root + 1/2) squared.
  always_ff @(posedge clk) begin
    if (en) begin
      magnitude <= root[SAMPLE_WIDTH] +
                   SAMPLE_WIDTH'(rem[SAMPLE_WIDTH] > REM_W'(root[SAMPLE_WIDTH]));
    end
  end

endmodule

>>> rtl/core/complex_to_magnitude_phase_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// complex_to_magnitude_phase_unit: rectangular to polar conversion
// Streams complex samples in and returns the rounded magnitude and the
// binary-angle phase of each one, one transfer per clock unless stalled.
// ============================================================================
// The unit accepts one complex sample in every clock cycle while the output
// is not stalled and returns one result per sample, in order. Each sample
// passes the input register, then two parallel pipelines, of which the
// longer sets the depth, then the output register. These are the CORDIC
// vectoring chain, one micro-rotation per stage, and the square-root chain,
// one root bit per stage plus a sum and a rounding stage. The magnitude is
// round(sqrt(re^2 + im^2)) and the phase is atan2(im, re) in units of
// pi/2^(SAMPLE_WIDTH-1), where the most negative code stands for plus or minus
// pi and the zero sample gives phase zero. The whole pipeline advances as one
// unit: it moves whenever the output register is empty or its result is taken
// in this cycle, so a stalled output holds every stage and no sample is lost
// or repeated. The unit keeps no state across samples.
// ============================================================================
module complex_to_magnitude_phase_unit
  import c2mp_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  // Sample channel.
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] real_part,
  input  logic signed [SAMPLE_WIDTH-1:0] imag_part,
  // Result channel.
  output logic                           polar_valid,
  input  logic                           polar_stall,
  output logic        [SAMPLE_WIDTH-1:0] magnitude,
  output logic signed [SAMPLE_WIDTH-1:0] phase
);

  // The pipeline advances unless a finished result is waiting and the
  // receiver holds it off. The input side stalls exactly then.
  logic en;
  assign en           = !(polar_valid && polar_stall);
  assign sample_stall = !en;

  // Valid bits and the zero-sample flag travel stage by stage with the data.
  // Index 0 is the input stage; index PIPE_LAT lines up with both results.
  logic vld      [0:PIPE_LAT];
  logic zero_smp [0:PIPE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= PIPE_LAT; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= sample_valid;
      for (int k = 1; k <= PIPE_LAT; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_smp[0] <= (real_part == '0) && (imag_part == '0);
      for (int k = 1; k <= PIPE_LAT; k++) begin
        zero_smp[k] <= zero_smp[k-1];
      end
    end
  end

  // Input stage: pre-rotation and squares.
  cordic_vec_t          vec0;
  logic [SQ_W-1:0]      re_sq;
  logic [SQ_W-1:0]      im_sq;

  c2mp_prep u_prep (
    .clk       (clk),
    .en        (en),
    .real_part (real_part),
    .imag_part (imag_part),
    .vec       (vec0),
    .re_sq     (re_sq),
    .im_sq     (im_sq)
  );

  // Phase path.
  logic [ANGLE_BITS-1:0]   z_final;
  logic [ANGLE_BITS-1:0]   z_round;
  logic [SAMPLE_WIDTH-1:0] phase_raw;
  logic [SAMPLE_WIDTH-1:0] phase_aligned;

  c2mp_cordic u_cordic (
    .clk    (clk),
    .en     (en),
    .vec_in (vec0),
    .z_out  (z_final)
  );

  // Round to nearest and keep the top bits; the accumulator wraps modulo a
  // full turn, so plus pi lands on the most negative code.
  assign z_round   = z_final + PHASE_ROUND;
  assign phase_raw = z_round[ANGLE_BITS-1 -: SAMPLE_WIDTH];

  // Magnitude path.
  logic [SAMPLE_WIDTH-1:0] mag_raw;
  logic [SAMPLE_WIDTH-1:0] mag_aligned;

  c2mp_sqrt u_sqrt (
    .clk       (clk),
    .en        (en),
    .re_sq     (re_sq),
    .im_sq     (im_sq),
    .magnitude (mag_raw)
  );

  // Whichever path is shorter is padded with plain delay registers so that
  // both results meet the valid bit at the end of the common depth.
  localparam int PHASE_PAD = PIPE_LAT - CORDIC_STAGES;
  localparam int MAG_PAD   = PIPE_LAT - MAG_LAT;

  if (PHASE_PAD > 0) begin : g_phase_pad
    logic [SAMPLE_WIDTH-1:0] line [0:PHASE_PAD-1];
    always_ff @(posedge clk) begin
      if (en) begin
        line[0] <= phase_raw;
        for (int k = 1; k < PHASE_PAD; k++) begin
          line[k] <= line[k-1];
        end
      end
    end
    assign phase_aligned = line[PHASE_PAD-1];
  end else begin : g_phase_direct
    assign phase_aligned = phase_raw;
  end

  if (MAG_PAD > 0) begin : g_mag_pad
    logic [SAMPLE_WIDTH-1:0] line [0:MAG_PAD-1];
    always_ff @(posedge clk) begin
      if (en) begin
        line[0] <= mag_raw;
        for (int k = 1; k < MAG_PAD; k++) begin
          line[k] <= line[k-1];
        end
      end
    end
    assign mag_aligned = line[MAG_PAD-1];
  end else begin : g_mag_direct
    assign mag_aligned = mag_raw;
  end

  // Output register. The zero sample has no defined angle, so its phase is
  // forced to zero here.
  always_ff @(posedge clk) begin
    if (rst) begin
      polar_valid <= 1'b0;
    end else if (en) begin
      polar_valid <= vld[PIPE_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      magnitude <= mag_aligned;
      phase     <= zero_smp[PIPE_LAT] ? '0 : signed'(phase_aligned);
    end
  end

endmodule

>>> verif/complex_to_magnitude_phase_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// complex_to_magnitude_phase_unit_tb: self-checking bench for the polar unit
// Streams complex samples through the converter under random sender bursts
// and receiver stalls. Each accepted sample is run through a bit-exact
// predictor (exact rounded integer root, CORDIC vectoring for the angle).
// Every output transfer is checked against the oldest prediction.
// ============================================================================
module complex_to_magnitude_phase_unit_tb
  import c2mp_pkg::*;
();

  // Predictor constants, kept in step with the unit's default build.
  localparam int ROT_STAGES = 18;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_SHIFT  = 32 - SAMPLE_WIDTH;

  // atan(2^-i), 2^32 units per full turn.
  localparam longint ARCTAN [0:ROT_STAGES-1] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F
  };

  localparam int RANDOM_SAMPLES = 1830;
  localparam int DRAIN_CYCLES   = 48;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] re;
    logic signed [SAMPLE_WIDTH-1:0] im;
  } sample_t;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] re;
    logic signed [SAMPLE_WIDTH-1:0] im;
    logic        [SAMPLE_WIDTH-1:0] mag;
    logic signed [SAMPLE_WIDTH-1:0] pha;
  } polar_t;

  // Receiver behavior for one stretch of cycles.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_SOLID
  } stall_mode_t;

  logic                           clk;
  logic                           rst          = 1'b1;
  logic                           sample_valid = 1'b0;
  logic                           sample_stall;
  logic signed [SAMPLE_WIDTH-1:0] real_part    = '0;
  logic signed [SAMPLE_WIDTH-1:0] imag_part    = '0;
  logic                           polar_valid;
  logic                           polar_stall  = 1'b0;
  logic        [SAMPLE_WIDTH-1:0] magnitude;
  logic signed [SAMPLE_WIDTH-1:0] phase;

  sample_t     sample_queue [$];
  polar_t      polar_expected [$];
  sample_t     staged;
  polar_t      oldest;
  int          mismatch_count = 0;
  int          gap_left       = 0;
  int          burst_left     = 1;
  int          stall_left     = 0;
  stall_mode_t stall_mode     = STALL_NONE;

  complex_to_magnitude_phase_unit uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .real_part    (real_part),
    .imag_part    (imag_part),
    .polar_valid  (polar_valid),
    .polar_stall  (polar_stall),
    .magnitude    (magnitude),
    .phase        (phase)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Rounded magnitude by an exact integer root, and the phase by the same
  // fixed-point vectoring sequence that the unit runs.
  function automatic polar_t polar_of(logic signed [SAMPLE_WIDTH-1:0] re_in,
                                      logic signed [SAMPLE_WIDTH-1:0] im_in);
    longint          re;
    longint          im;
    longint          x;
    longint          y;
    longint          z;
    longint          xs;
    longint          ys;
    longint          t;
    longint unsigned are;
    longint unsigned aim;
    longint unsigned sum;
    longint unsigned root;
    longint unsigned rem;
    longint unsigned probe;
    polar_t          r;
    re = re_in;
    im = im_in;
    are = (re < 0) ? -re : re;
    aim = (im < 0) ? -im : im;
    sum = are * are + aim * aim;
    root = 0;
    rem = sum;
    probe = 64'h4000_0000_0000_0000;
    while (probe > sum) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    // Round up when sqrt(sum) lies above root + 1/2.
    if (rem > root) root = root + 1;
    z = 0;
    if (re != 0 || im != 0) begin
      x = re * (longint'(1) <<< FRAC_BITS);
      y = im * (longint'(1) <<< FRAC_BITS);
      // Fold the left half plane onto the right one by a quarter turn.
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = longint'(1) <<< 30;
        end else begin
          x = -y;
          y = t;
          z = -(longint'(1) <<< 30);
        end
      end
      for (int i = 0; i < ROT_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ARCTAN[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ARCTAN[i];
        end
      end
      z = (z + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    end
    r.re  = re_in;
    r.im  = im_in;
    r.mag = root[SAMPLE_WIDTH-1:0];
    r.pha = z[SAMPLE_WIDTH-1:0];
    return r;
  endfunction

  task automatic queue_sample(int re, int im);
    sample_t s;
    s.re = re[SAMPLE_WIDTH-1:0];
    s.im = im[SAMPLE_WIDTH-1:0];
    sample_queue.push_back(s);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 6))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return 32766;
      default: return 32767;
    endcase
  endfunction

  // Sender: bursts of random length separated by random gaps. A payload that
  // is offered stays put until the transfer happens.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        polar_expected.push_back(polar_of(real_part, imag_part));
      end
      if (!sample_valid || !sample_stall) begin
        if (gap_left != 0 || sample_queue.size() == 0) begin
          sample_valid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          staged = sample_queue.pop_front();
          sample_valid <= 1'b1;
          real_part    <= staged.re;
          imag_part    <= staged.im;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver: stretches of free flow, random stalls and solid stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode  <= stall_mode_t'($urandom_range(0, 3));
      stall_left  <= $urandom_range(1, 48);
      polar_stall <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        STALL_NONE:  polar_stall <= 1'b0;
        STALL_COIN:  polar_stall <= $urandom_range(0, 1);
        STALL_HEAVY: polar_stall <= ($urandom_range(0, 3) != 0);
        default:     polar_stall <= 1'b1;
      endcase
    end
  end

  // Monitor: every output transfer must match the oldest prediction.
  always @(posedge clk) begin
    if (!rst && polar_valid && !polar_stall) begin
      if (polar_expected.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected result: mag %0d phase %0d", magnitude, phase);
      end else begin
        oldest = polar_expected.pop_front();
        if (magnitude !== oldest.mag || phase !== oldest.pha) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < MAX_REPORTS)
            $display("mismatch for (%0d, %0d): expected mag %0d phase %0d, got mag %0d phase %0d",
                     oldest.re, oldest.im, oldest.mag, oldest.pha, magnitude, phase);
        end
      end
    end
  end

  // Stimulus, reset and the end of the run.
  initial begin
    int kind;
    int a;
    int b;
    // Directed: zero sample, corners, axes, the negative real axis and the
    // wrap at plus pi, plus a few small and diagonal vectors.
    queue_sample(0, 0);
    queue_sample(32767, 0);
    queue_sample(-32768, 0);
    queue_sample(0, 32767);
    queue_sample(0, -32768);
    queue_sample(32767, 32767);
    queue_sample(-32768, -32768);
    queue_sample(-32768, 32767);
    queue_sample(32767, -32768);
    queue_sample(1, 0);
    queue_sample(-1, 0);
    queue_sample(0, 1);
    queue_sample(0, -1);
    queue_sample(-1, -1);
    queue_sample(-1, 1);
    queue_sample(-5, 0);
    queue_sample(-32768, 1);
    queue_sample(-32768, -1);
    queue_sample(-32767, 0);
    queue_sample(1, 1);
    queue_sample(3, 4);
    queue_sample(100, -100);
    queue_sample(-12345, 6789);
    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        a = $urandom;
        b = $urandom;
      end else if (kind < 55) begin
        a = $urandom_range(0, 16) - 8;
        b = $urandom_range(0, 16) - 8;
      end else if (kind < 70) begin
        // Close to the negative real axis, where the angle wraps.
        a = -$urandom_range(1, 32768);
        b = $urandom_range(0, 6) - 3;
      end else if (kind < 80) begin
        a = $urandom;
        b = 0;
        if ($urandom_range(0, 1) == 1) begin
          b = a;
          a = 0;
        end
      end else if (kind < 90) begin
        a = pick_extreme();
        b = pick_extreme();
      end else begin
        a = $urandom_range(0, 32767);
        b = ($urandom_range(0, 1) == 1) ? a : -a;
        if ($urandom_range(0, 1) == 1) a = -a;
      end
      queue_sample(a, b);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (sample_queue.size() != 0 || sample_valid || polar_expected.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
